>>> hdl/hrlp_pkg.sv
package hrlp_pkg;

  // Characters the parser looks for
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;

  // Limit register reset values
  localparam logic [7:0] METHOD_LIMIT_RST  = 8'd10;
  localparam logic [7:0] PATH_LIMIT_RST    = 8'd255;
  localparam logic [7:0] VERSION_LIMIT_RST = 8'd30;
  localparam logic [7:0] COUNT_MAX         = 8'd255;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_METHOD_LIMIT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATH_LIMIT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VERSION_LIMIT = 2'd2;

  // Field tags
  localparam logic [1:0] TAG_METHOD  = 2'd0;
  localparam logic [1:0] TAG_PATH    = 2'd1;
  localparam logic [1:0] TAG_VERSION = 2'd2;
  localparam logic [1:0] TAG_AFTER   = 2'd3;

  // Line status codes
  localparam logic [1:0] ST_PROGRESS = 2'd0;
  localparam logic [1:0] ST_FIN_NOW  = 2'd1;
  localparam logic [1:0] ST_INVALID  = 2'd2;
  localparam logic [1:0] ST_FINISHED = 2'd3;

  // Output queue sizing: one byte may cause two results
  localparam int QDEPTH = 3;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Parser phase, one-hot
  typedef enum logic [4:0] {
    PH_METHOD  = 5'b00001,
    PH_PATH    = 5'b00010,
    PH_VERSION = 5'b00100,
    PH_DONE    = 5'b01000,
    PH_INVALID = 5'b10000
  } phase_t;

  // One result item
  typedef struct packed {
    logic [7:0] data;
    logic       byte_valid;
    logic [1:0] field_tag;
    logic [1:0] status;
    logic       last;
  } result_t;

  // Results caused by one accepted byte
  typedef struct packed {
    result_t first;
    result_t second;
    logic    two;
  } result_pair_t;

endpackage

>>> hdl/hrlp_parse.sv
module hrlp_parse
  import hrlp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  input  logic                 accept,
  input  logic [7:0]           data_byte,
  output result_pair_t         res
);

  logic [7:0] method_limit_r, path_limit_r, version_limit_r;
  phase_t     phase_r, phase_nxt;
  logic [7:0] field_count_r, field_count_nxt;
  logic       cr_pending_r, cr_pending_nxt;

  logic [7:0] count_inc;
  logic [7:0] limit_sel;
  logic       limit_hit;
  result_t    r_bad, r_tail;

  // Limit registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      method_limit_r  <= METHOD_LIMIT_RST;
      path_limit_r    <= PATH_LIMIT_RST;
      version_limit_r <= VERSION_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_METHOD_LIMIT:  method_limit_r  <= cfg_data;
        CFG_PATH_LIMIT:    path_limit_r    <= cfg_data;
        CFG_VERSION_LIMIT: version_limit_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Saturating field length and limit check for the current field
  always_comb begin
    count_inc = (field_count_r < COUNT_MAX) ? field_count_r + 8'd1 : field_count_r;
    case (phase_r)
      PH_METHOD: limit_sel = method_limit_r;
      PH_PATH:   limit_sel = path_limit_r;
      default:   limit_sel = version_limit_r;
    endcase
    limit_hit = (count_inc >= limit_sel);
  end

  // Classify the byte and build its results
  always_comb begin
    r_bad  = '{data: data_byte, byte_valid: 1'b0, field_tag: TAG_METHOD,
               status: ST_INVALID, last: 1'b1};
    r_tail = '{data: data_byte, byte_valid: 1'b1, field_tag: TAG_VERSION,
               status: ST_PROGRESS, last: 1'b1};
    phase_nxt       = phase_r;
    field_count_nxt = field_count_r;
    cr_pending_nxt  = cr_pending_r;
    res.first       = r_bad;
    res.second      = r_bad;
    res.two         = 1'b0;

    case (phase_r)
      PH_METHOD: begin
        if (data_byte == CH_SPACE) begin
          phase_nxt       = PH_PATH;
          field_count_nxt = '0;
          res.first       = '{data: data_byte, byte_valid: 1'b0, field_tag: TAG_METHOD,
                              status: ST_PROGRESS, last: 1'b1};
        end else if (limit_hit) begin
          phase_nxt      = PH_INVALID;
          cr_pending_nxt = 1'b0;
        end else begin
          field_count_nxt = count_inc;
          res.first       = '{data: data_byte, byte_valid: 1'b1, field_tag: TAG_METHOD,
                              status: ST_PROGRESS, last: 1'b1};
        end
      end

      PH_PATH: begin
        if (field_count_r == 8'd0 && data_byte != CH_SLASH) begin
          phase_nxt      = PH_INVALID;
          cr_pending_nxt = 1'b0;
        end else if (data_byte == CH_SPACE) begin
          phase_nxt       = PH_VERSION;
          field_count_nxt = '0;
          cr_pending_nxt  = 1'b0;
          res.first       = '{data: data_byte, byte_valid: 1'b0, field_tag: TAG_PATH,
                              status: ST_PROGRESS, last: 1'b1};
        end else if (limit_hit) begin
          phase_nxt      = PH_INVALID;
          cr_pending_nxt = 1'b0;
        end else begin
          field_count_nxt = count_inc;
          res.first       = '{data: data_byte, byte_valid: 1'b1, field_tag: TAG_PATH,
                              status: ST_PROGRESS, last: 1'b1};
        end
      end

      PH_VERSION: begin
        if (data_byte == CH_LF) begin
          phase_nxt      = PH_DONE;
          cr_pending_nxt = 1'b0;
          res.first      = '{data: data_byte, byte_valid: 1'b0, field_tag: TAG_VERSION,
                             status: ST_FIN_NOW, last: 1'b1};
        end else if (limit_hit) begin
          phase_nxt      = PH_INVALID;
          cr_pending_nxt = 1'b0;
        end else begin
          field_count_nxt = count_inc;
          // hold a CR back until the next byte shows whether LF follows
          if (data_byte == CH_CR) begin
            cr_pending_nxt    = 1'b1;
            r_tail.byte_valid = 1'b0;
          end else begin
            cr_pending_nxt = 1'b0;
          end
          if (cr_pending_r) begin
            res.first  = '{data: CH_CR, byte_valid: 1'b1, field_tag: TAG_VERSION,
                           status: ST_PROGRESS, last: 1'b0};
            res.second = r_tail;
            res.two    = 1'b1;
          end else begin
            res.first = r_tail;
          end
        end
      end

      PH_DONE: begin
        res.first = '{data: data_byte, byte_valid: 1'b1, field_tag: TAG_AFTER,
                      status: ST_FINISHED, last: 1'b1};
      end

      default: begin
        phase_nxt      = PH_INVALID;
        cr_pending_nxt = 1'b0;
      end
    endcase
  end

  // Advance parser state on each transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_METHOD;
      field_count_r <= '0;
      cr_pending_r  <= 1'b0;
    end else if (accept) begin
      phase_r       <= phase_nxt;
      field_count_r <= field_count_nxt;
      cr_pending_r  <= cr_pending_nxt;
    end
  end

endmodule

>>> hdl/hrlp_oq.sv
module hrlp_oq
  import hrlp_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  result_pair_t res,
  output logic         full,
  output logic         head_valid,
  input  logic         head_stall,
  output result_t      head
);

  result_t           q_r   [QDEPTH];
  result_t           q_nxt [QDEPTH];
  logic [QCNT_W-1:0] cnt_r, cnt_nxt, cnt_pop;
  logic              pop;

  assign head_valid = (cnt_r != '0);
  assign pop        = head_valid && !head_stall;
  // Take a byte only while there is room for two results
  assign full       = (cnt_r >= QCNT_W'(QDEPTH - 1));
  assign head       = q_r[0];

  // Shift out the head, then append the new results behind what is left
  always_comb begin
    cnt_pop = cnt_r - QCNT_W'(pop);
    q_nxt   = q_r;
    if (pop) begin
      for (int i = 0; i < QDEPTH - 1; i++) q_nxt[i] = q_r[i+1];
    end
    for (int i = 0; i < QDEPTH; i++) begin
      if (push && QCNT_W'(i) == cnt_pop)
        q_nxt[i] = res.first;
      else if (push && res.two && QCNT_W'(i) == cnt_pop + QCNT_W'(1))
        q_nxt[i] = res.second;
    end
    cnt_nxt = cnt_pop + QCNT_W'(push) + QCNT_W'(push && res.two);
  end

  // Count of held results
  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= '0;
    else        cnt_r <= cnt_nxt;
  end

  // Result slots
  always_ff @(posedge clk) begin
    for (int i = 0; i < QDEPTH; i++) q_r[i] <= q_nxt[i];
  end

endmodule

>>> hdl/http_request_line_parser.sv
// Channel   Handshake                Payload
// in_       in_valid / in_stall      in_data_byte
// out_      out_valid / out_stall    out_byte, out_byte_valid, out_field_tag,
//                                    out_status, out_last
// cfg_      cfg_we                   cfg_index, cfg_data
//
// One byte is taken per cycle while in_stall is low, and its results are
// registered into a three-slot output queue behind any results it holds.
// A held CR followed by another version byte yields two results; the queue
// drains one per cycle unless out_stall; in_stall rises while two slots hold.
// rst_n is synchronous: limits return to 10/255/30 and parsing restarts.
module http_request_line_parser
  import hrlp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_data_byte,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           out_byte,
  output logic                 out_byte_valid,
  output logic [1:0]           out_field_tag,
  output logic [1:0]           out_status,
  output logic                 out_last,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  logic         accept;
  result_pair_t res;
  result_t      head;

  assign accept = in_valid && !in_stall;

  // Byte classifier and line state
  hrlp_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .data_byte (in_data_byte),
    .res       (res)
  );

  // Result register queue
  hrlp_oq u_oq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (accept),
    .res        (res),
    .full       (in_stall),
    .head_valid (out_valid),
    .head_stall (out_stall),
    .head       (head)
  );

  assign out_byte       = head.data;
  assign out_byte_valid = head.byte_valid;
  assign out_field_tag  = head.field_tag;
  assign out_status     = head.status;
  assign out_last       = head.last;

endmodule

>>> tb/http_request_line_parser_checker.sv
`timescale 1ns / 1ps

module http_request_line_parser_checker
  import hrlp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [7:0]           in_data_byte,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [7:0]           out_byte,
  input  logic                 out_byte_valid,
  input  logic [1:0]           out_field_tag,
  input  logic [1:0]           out_status,
  input  logic                 out_last,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  output int                   fail_count,
  output int                   pending,
  output int                   results_seen,
  output int                   pair_count,
  output phase_t               line_phase,
  output logic [7:0]           line_count
);

  localparam int MAX_REPORTS = 100;

  logic [7:0] method_lim;
  logic [7:0] path_lim;
  logic [7:0] version_lim;
  logic       cr_held;

  // Tagged bytes the parser owes us, oldest first
  result_t tagged_q[$];

  task automatic add_tagged(input logic [7:0] b, input logic v, input logic [1:0] tag,
                            input logic [1:0] st, input logic lst);
    result_t r;
    r.data       = b;
    r.byte_valid = v;
    r.field_tag  = tag;
    r.status     = st;
    r.last       = lst;
    tagged_q.push_back(r);
  endtask

  // Kill the line; it stays invalid until reset
  task automatic mark_invalid(input logic [7:0] b);
    line_phase = PH_INVALID;
    cr_held    = 1'b0;
    add_tagged(b, 1'b0, TAG_METHOD, ST_INVALID, 1'b1);
  endtask

  // Count one more byte of the field; true once the limit is reached
  function automatic bit count_reaches(input logic [7:0] limit);
    if (line_count < COUNT_MAX) line_count++;
    return line_count >= limit;
  endfunction

  // Split one stream byte into the tagged bytes it causes
  task automatic split_byte(input logic [7:0] b);
    case (line_phase)
      PH_METHOD: begin
        if (b == CH_SPACE) begin
          line_phase = PH_PATH;
          line_count = '0;
          add_tagged(b, 1'b0, TAG_METHOD, ST_PROGRESS, 1'b1);
        end else if (count_reaches(method_lim)) begin
          mark_invalid(b);
        end else begin
          add_tagged(b, 1'b1, TAG_METHOD, ST_PROGRESS, 1'b1);
        end
      end
      PH_PATH: begin
        if (line_count == 0 && b != CH_SLASH) begin
          mark_invalid(b);
        end else if (b == CH_SPACE) begin
          line_phase = PH_VERSION;
          line_count = '0;
          cr_held    = 1'b0;
          add_tagged(b, 1'b0, TAG_PATH, ST_PROGRESS, 1'b1);
        end else if (count_reaches(path_lim)) begin
          mark_invalid(b);
        end else begin
          add_tagged(b, 1'b1, TAG_PATH, ST_PROGRESS, 1'b1);
        end
      end
      PH_VERSION: begin
        if (b == CH_LF) begin
          line_phase = PH_DONE;
          cr_held    = 1'b0;
          add_tagged(b, 1'b0, TAG_VERSION, ST_FIN_NOW, 1'b1);
        end else if (count_reaches(version_lim)) begin
          mark_invalid(b);
        end else begin
          // Release a held CR ahead of the new byte
          if (cr_held) begin
            add_tagged(CH_CR, 1'b1, TAG_VERSION, ST_PROGRESS, 1'b0);
            pair_count++;
          end
          cr_held = (b == CH_CR);
          add_tagged(b, !cr_held, TAG_VERSION, ST_PROGRESS, 1'b1);
        end
      end
      PH_DONE: begin
        add_tagged(b, 1'b1, TAG_AFTER, ST_FINISHED, 1'b1);
      end
      default: begin
        mark_invalid(b);
      end
    endcase
  endtask

  // Watch both channels and the register port on every rising edge
  always @(posedge clk) begin : watch
    result_t want;
    if (!rst_n) begin
      method_lim   = METHOD_LIMIT_RST;
      path_lim     = PATH_LIMIT_RST;
      version_lim  = VERSION_LIMIT_RST;
      line_phase   = PH_METHOD;
      line_count   = '0;
      cr_held      = 1'b0;
      fail_count   = 0;
      results_seen = 0;
      pair_count   = 0;
      tagged_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_METHOD_LIMIT:  method_lim  = cfg_data;
          CFG_PATH_LIMIT:    path_lim    = cfg_data;
          CFG_VERSION_LIMIT: version_lim = cfg_data;
          default: ;
        endcase
      end

      // Compare each result transfer with the oldest tagged byte owed
      if (out_valid && !out_stall) begin
        results_seen++;
        if (tagged_q.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS) begin
            $write("%0t: unexpected result: expected none, got byte %02h valid %0b tag %0d",
                   $time, out_byte, out_byte_valid, out_field_tag);
            $display(" status %0d last %0b", out_status, out_last);
          end
        end else begin
          want = tagged_q.pop_front();
          if (out_byte !== want.data || out_byte_valid !== want.byte_valid ||
              out_field_tag !== want.field_tag || out_status !== want.status ||
              out_last !== want.last) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS) begin
              $write("%0t: mismatch: expected byte %02h valid %0b tag %0d status %0d",
                     $time, want.data, want.byte_valid, want.field_tag, want.status);
              $write(" last %0b, got byte %02h valid %0b", want.last, out_byte,
                     out_byte_valid);
              $display(" tag %0d status %0d last %0b", out_field_tag, out_status,
                       out_last);
            end
          end
        end
      end

      if (in_valid && !in_stall) split_byte(in_data_byte);
    end
    pending = tagged_q.size();
  end

endmodule

>>> tb/http_request_line_parser_tb.sv
`timescale 1ns / 1ps

module http_request_line_parser_tb;
  import hrlp_pkg::*;

  localparam int ITEMS_PER_RUN = 400;
  localparam int HOLD_CYCLES   = 64;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_LIMIT   = 2000;
  localparam int CYCLE_LIMIT   = 200_000;

  // How the one request line of this run is meant to end
  typedef enum logic [2:0] {
    LINE_WHOLE,
    LONG_METHOD,
    NO_SLASH,
    EMPTY_PATH,
    LONG_PATH,
    LONG_VERSION
  } line_fate_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [7:0]           in_data_byte;
  logic                 out_valid;
  logic                 out_stall;
  logic [7:0]           out_byte;
  logic                 out_byte_valid;
  logic [1:0]           out_field_tag;
  logic [1:0]           out_status;
  logic                 out_last;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [7:0]           cfg_data;

  int         fail_count;
  int         pending;
  int         results_seen;
  int         pair_count;
  phase_t     line_phase;
  logic [7:0] line_count;

  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  bit         hold_go = 1'b0;
  int         cycle_count = 0;
  int         items_sent = 0;
  line_fate_t fate;
  int         method_len;
  int         path_len;
  int         version_len;
  logic [7:0] lim_method;
  logic [7:0] lim_path;
  logic [7:0] lim_version;

  http_request_line_parser u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data_byte   (in_data_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_byte_valid (out_byte_valid),
    .out_field_tag  (out_field_tag),
    .out_status     (out_status),
    .out_last       (out_last),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  http_request_line_parser_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data_byte   (in_data_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_byte_valid (out_byte_valid),
    .out_field_tag  (out_field_tag),
    .out_status     (out_status),
    .out_last       (out_last),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .fail_count     (fail_count),
    .pending        (pending),
    .results_seen   (results_seen),
    .pair_count     (pair_count),
    .line_phase     (line_phase),
    .line_count     (line_count)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Give up on a hung run
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("[http_request_line_parser] ERROR");
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off once asked
  initial begin
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (hold_go && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Uniform random byte other than the one given
  function automatic logic [7:0] any_byte_but(input logic [7:0] skip);
    logic [7:0] b;
    b = 8'($urandom_range(254));
    if (b >= skip) b++;
    return b;
  endfunction

  // Choose the next stream byte from where the line stands now
  function automatic logic [7:0] next_stream_byte();
    logic [7:0] b;
    int r;
    int cnt;
    cnt = line_count;
    r   = $urandom_range(99);
    case (line_phase)
      PH_METHOD: begin
        if (fate != LONG_METHOD && (cnt >= method_len || cnt + 1 >= lim_method))
          b = CH_SPACE;
        else if (r < 70)
          b = 8'($urandom_range(8'h5A, 8'h41));  // upper-case token letter
        else
          b = any_byte_but(CH_SPACE);
      end
      PH_PATH: begin
        if (cnt == 0) begin
          if (fate == NO_SLASH) b = any_byte_but(CH_SLASH);
          else if (fate == EMPTY_PATH) b = CH_SPACE;
          else b = CH_SLASH;
        end else if (fate != LONG_PATH && (cnt >= path_len || cnt + 1 >= lim_path)) begin
          b = CH_SPACE;
        end else if (r < 60) begin
          b = 8'($urandom_range(8'h7E, 8'h21));
        end else begin
          b = any_byte_but(CH_SPACE);
        end
      end
      PH_VERSION: begin
        if (fate != LONG_VERSION && (cnt >= version_len || cnt + 1 >= lim_version))
          b = CH_LF;
        else if (r < 20 || (fate != LONG_VERSION && cnt + 1 == version_len))
          b = CH_CR;
        else if (r < 80)
          b = 8'($urandom_range(8'h7E, 8'h20));
        else
          b = any_byte_but(CH_LF);
      end
      default: begin
        // Line is over: mix separators into plain noise
        if (r < 25) begin
          case ($urandom_range(3))
            0: b = CH_SPACE;
            1: b = CH_SLASH;
            2: b = CH_CR;
            default: b = CH_LF;
          endcase
        end else begin
          b = 8'($urandom_range(255));
        end
      end
    endcase
    return b;
  endfunction

  // Offer one byte after optional idle cycles; hold it until the transfer
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic run_items(input int n);
    repeat (n) send_byte(next_stream_byte());
  endtask

  task automatic write_limit(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Stop offering, let every owed result drain, then settle
  task automatic wait_idle();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (pending != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Limits that keep a live field alive, or anything for a finished one
  function automatic logic [7:0] pick_limit(input bit live, input int lo);
    int r;
    r = $urandom_range(99);
    if (live) begin
      if (r < 25) return 8'(lo);
      if (r < 50) return COUNT_MAX;
      return 8'($urandom_range(255, lo));
    end
    if (r < 20) return 8'd0;
    if (r < 40) return COUNT_MAX;
    return 8'($urandom_range(255));
  endfunction

  task automatic retune_limits();
    bit at_method;
    bit up_to_path;
    bit up_to_version;
    at_method     = (line_phase == PH_METHOD);
    up_to_path    = at_method || line_phase == PH_PATH;
    up_to_version = up_to_path || line_phase == PH_VERSION;
    lim_method  = pick_limit(at_method && fate != LONG_METHOD, 1);
    lim_path    = pick_limit(up_to_path && fate != LONG_PATH, 2);
    lim_version = pick_limit(up_to_version && fate != LONG_VERSION, 1);
    write_limit(CFG_METHOD_LIMIT, lim_method);
    write_limit(CFG_PATH_LIMIT, lim_path);
    write_limit(CFG_VERSION_LIMIT, lim_version);
  endtask

  initial begin
    int r;
    in_valid     = 1'b0;
    in_data_byte = '0;
    cfg_we       = 1'b0;
    cfg_index    = CFG_METHOD_LIMIT;
    cfg_data     = '0;
    rst_n        = 1'b0;

    // Decide how this line ends and how long its fields run
    r    = $urandom_range(9);
    fate = (r < 5) ? LINE_WHOLE : line_fate_t'(r - 4);
    method_len  = ($urandom_range(1)) ? $urandom_range(8) : $urandom_range(254);
    path_len    = ($urandom_range(1)) ? $urandom_range(16, 1) : $urandom_range(254, 1);
    version_len = ($urandom_range(1)) ? $urandom_range(12) : $urandom_range(254);

    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Open every limit to its top value
    lim_method  = COUNT_MAX;
    lim_path    = COUNT_MAX;
    lim_version = COUNT_MAX;
    write_limit(CFG_METHOD_LIMIT, lim_method);
    write_limit(CFG_PATH_LIMIT, lim_path);
    write_limit(CFG_VERSION_LIMIT, lim_version);

    // Sender idles a third of the time, receiver mostly stalls
    send_idle_pct = 33;
    recv_idle_pct = 73;

    // Method bytes at the edges of the byte range and lookalike separators
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h7F);
    send_byte(8'h80);
    send_byte(8'h55);
    send_byte(8'hAA);
    send_byte(CH_CR);
    send_byte(CH_LF);
    send_byte(CH_SLASH);
    run_items(ITEMS_PER_RUN - 9);
    wait_idle();

    // Swap the idle rates under new limits
    retune_limits();
    send_idle_pct = 73;
    recv_idle_pct = 33;
    run_items(ITEMS_PER_RUN);
    wait_idle();

    // Full rate, with one long receiver hold-off to back up the input
    retune_limits();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_go       = 1'b1;
    run_items(ITEMS_PER_RUN);
    wait_idle();

    $display("Sent %0d bytes, checked %0d results, %0d of them a released CR.",
             items_sent, results_seen, pair_count);
    $display("Line plan %s, parser ended in %s.", fate.name(), line_phase.name());
    if (fail_count == 0 && pending == 0) begin
      $display("[http_request_line_parser] OK");
    end else begin
      $display("[http_request_line_parser] ERROR");
    end
    $finish;
  end

endmodule
